// ===== rtl/wrr_pkg.sv =====
// ----------------------------------------------------------------------------
// wrr_pkg
// Shared constants and register codes for the weighted random child pick.
// ----------------------------------------------------------------------------
package wrr_pkg;

  // default slot count and weight width
  localparam int MAX_SLOTS_DEF   = 8;
  localparam int WEIGHT_BITS_DEF = 16;

  // random fraction width, threshold is (roll * total) >> ROLL_BITS
  localparam int ROLL_BITS = 16;

  // stored previous winner, all ones means no previous choice
  localparam int                   PREV_BITS = 4;
  localparam logic [PREV_BITS-1:0] NO_WINNER = 4'd15;

  // configuration registers
  localparam int                    COUNT_BITS        = 4;
  localparam logic [COUNT_BITS-1:0] CHILD_COUNT_RESET = 4'd8;
  localparam int                    CFG_IDX_BITS      = 1;
  localparam int                    CFG_DATA_BITS     = 4;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_AVOID_REPEAT = 1'b0,
    CFG_CHILD_COUNT  = 1'b1
  } cfg_reg_t;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

endpackage

// ===== rtl/wrr_if.sv =====
// ----------------------------------------------------------------------------
// wrr channel interfaces
// Request, result and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface wrr_in_if #(
  parameter int MAX_SLOTS   = wrr_pkg::MAX_SLOTS_DEF,
  parameter int WEIGHT_BITS = wrr_pkg::WEIGHT_BITS_DEF
) ();
  logic                               valid;
  logic                               ready;
  logic [MAX_SLOTS-1:0]               eligible_mask;
  logic [MAX_SLOTS*WEIGHT_BITS-1:0]   weight;
  logic [wrr_pkg::ROLL_BITS-1:0]      roll;

  modport source (output valid, eligible_mask, weight, roll, input ready);
  modport sink   (input valid, eligible_mask, weight, roll, output ready);
endinterface

interface wrr_out_if #(
  parameter int MAX_SLOTS = wrr_pkg::MAX_SLOTS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic [$clog2(MAX_SLOTS)-1:0] chosen_slot;
  logic                         choice_made;

  modport source (output valid, chosen_slot, choice_made, input ready);
  modport sink   (input valid, chosen_slot, choice_made, output ready);
endinterface

interface wrr_cfg_if ();
  logic                              valid;
  logic                              ready;
  logic [wrr_pkg::CFG_IDX_BITS-1:0]  index;
  logic [wrr_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/wrr_front.sv =====
// ----------------------------------------------------------------------------
// wrr_front
// Three stage front: classifies candidates, forms prefix sums and the
// roll products that the back needs for its combinational decision.
// ----------------------------------------------------------------------------
module wrr_front #(
  parameter int MAX_SLOTS   = wrr_pkg::MAX_SLOTS_DEF,
  parameter int WEIGHT_BITS = wrr_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // request side
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [MAX_SLOTS-1:0]                     in_mask,
  input  logic [MAX_SLOTS-1:0][WEIGHT_BITS-1:0]    in_weight,
  input  logic [wrr_pkg::ROLL_BITS-1:0]            in_roll,
  input  logic [wrr_pkg::COUNT_BITS-1:0]           child_count,
  // queue side
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [MAX_SLOTS-1:0]                     out_cand,
  output logic [MAX_SLOTS-1:0][WEIGHT_BITS-1:0]    out_weight,
  output logic [MAX_SLOTS-1:0][WEIGHT_BITS+$clog2(MAX_SLOTS)-1:0] out_prefix,
  output logic [MAX_SLOTS-1:0][WEIGHT_BITS+wrr_pkg::ROLL_BITS-1:0] out_rw,
  output logic [WEIGHT_BITS+$clog2(MAX_SLOTS)+wrr_pkg::ROLL_BITS-1:0] out_rt
);

  localparam int RB   = wrr_pkg::ROLL_BITS;
  localparam int SW   = WEIGHT_BITS + $clog2(MAX_SLOTS);
  localparam int PW   = WEIGHT_BITS + RB;
  localparam int TW   = SW + RB;
  localparam int LVLS = $clog2(MAX_SLOTS);

  // stage registers
  logic                                  s1_v_r, s2_v_r, s3_v_r;
  logic [MAX_SLOTS-1:0]                  s1_cand_r, s2_cand_r, s3_cand_r;
  logic [MAX_SLOTS-1:0][WEIGHT_BITS-1:0] s1_w_r, s2_w_r, s3_w_r;
  logic [RB-1:0]                         s1_roll_r, s2_roll_r;
  logic [MAX_SLOTS-1:0][SW-1:0]          s2_prefix_r, s3_prefix_r;
  logic [MAX_SLOTS-1:0][PW-1:0]          s2_rw_r, s3_rw_r;
  logic [TW-1:0]                         s3_rt_r;

  logic                                  s1_rdy, s2_rdy, s3_rdy;
  logic [MAX_SLOTS-1:0]                  cand_nxt;
  logic [SW-1:0]                         pre [LVLS+1][MAX_SLOTS];
  logic [MAX_SLOTS-1:0][PW-1:0]          rw_nxt;
  logic [TW-1:0]                         rt_nxt;

  // stall chain, a stage loads when empty or when it moves on
  assign s3_rdy   = !s3_v_r || out_ready;
  assign s2_rdy   = !s2_v_r || s3_rdy;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_ready = s1_rdy;

  // candidate: eligible, below the slot count and nonzero weight
  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      cand_nxt[i] = in_mask[i] && (wrr_pkg::COUNT_BITS'(i) < child_count) &&
                    (in_weight[i] != '0);
    end
  end

  // inclusive prefix sums over candidate weights, log depth
  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      pre[0][i] = s1_cand_r[i] ? SW'(s1_w_r[i]) : '0;
    end
    for (int k = 0; k < LVLS; k++) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        if (i >= (1 << k)) begin
          pre[k+1][i] = pre[k][i] + pre[k][i-(1<<k)];
        end else begin
          pre[k+1][i] = pre[k][i];
        end
      end
    end
  end

  // roll times each weight, one multiplier per slot
  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      rw_nxt[i] = PW'(s1_roll_r) * PW'(s1_w_r[i]);
    end
  end

  // roll times total weight
  assign rt_nxt = TW'(s2_roll_r) * TW'(s2_prefix_r[MAX_SLOTS-1]);

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= in_valid;
      if (s2_rdy) s2_v_r <= s1_v_r;
      if (s3_rdy) s3_v_r <= s2_v_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      s1_cand_r <= cand_nxt;
      s1_w_r    <= in_weight;
      s1_roll_r <= in_roll;
    end
    if (s2_rdy && s1_v_r) begin
      s2_cand_r <= s1_cand_r;
      s2_w_r    <= s1_w_r;
      s2_roll_r <= s1_roll_r;
      s2_rw_r   <= rw_nxt;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        s2_prefix_r[i] <= pre[LVLS][i];
      end
    end
    if (s3_rdy && s2_v_r) begin
      s3_cand_r   <= s2_cand_r;
      s3_w_r      <= s2_w_r;
      s3_prefix_r <= s2_prefix_r;
      s3_rw_r     <= s2_rw_r;
      s3_rt_r     <= rt_nxt;
    end
  end

  assign out_valid  = s3_v_r;
  assign out_cand   = s3_cand_r;
  assign out_weight = s3_w_r;
  assign out_prefix = s3_prefix_r;
  assign out_rw     = s3_rw_r;
  assign out_rt     = s3_rt_r;

endmodule

// ===== rtl/wrr_queue.sv =====
// ----------------------------------------------------------------------------
// wrr_queue
// Small register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module wrr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = wrr_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_BITS-1:0] count_r;
  logic                push, pop;

  assign wr_ready = (count_r != CNT_BITS'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

// ===== rtl/wrr_back.sv =====
// ----------------------------------------------------------------------------
// wrr_back
// Drops the previous winner where asked, picks the first candidate whose sum
// passes the threshold, else the last, registers the result and the winner.
// ----------------------------------------------------------------------------
module wrr_back #(
  parameter int MAX_SLOTS   = wrr_pkg::MAX_SLOTS_DEF,
  parameter int WEIGHT_BITS = wrr_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     avoid_repeat,
  // queue side
  input  logic                                     q_valid,
  output logic                                     q_ready,
  input  logic [MAX_SLOTS-1:0]                     q_cand,
  input  logic [MAX_SLOTS-1:0][WEIGHT_BITS-1:0]    q_weight,
  input  logic [MAX_SLOTS-1:0][WEIGHT_BITS+$clog2(MAX_SLOTS)-1:0] q_prefix,
  input  logic [MAX_SLOTS-1:0][WEIGHT_BITS+wrr_pkg::ROLL_BITS-1:0] q_rw,
  input  logic [WEIGHT_BITS+$clog2(MAX_SLOTS)+wrr_pkg::ROLL_BITS-1:0] q_rt,
  // result side
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [$clog2(MAX_SLOTS)-1:0]             out_chosen_slot,
  output logic                                     out_choice_made
);

  localparam int RB   = wrr_pkg::ROLL_BITS;
  localparam int SW   = WEIGHT_BITS + $clog2(MAX_SLOTS);
  localparam int PW   = WEIGHT_BITS + RB;
  localparam int TW   = SW + RB;
  localparam int CW   = TW + 1;
  localparam int IDXW = $clog2(MAX_SLOTS);
  localparam int PB   = wrr_pkg::PREV_BITS;

  logic                   out_valid_r;
  logic [IDXW-1:0]        slot_r;
  logic                   made_r;
  logic [PB-1:0]          prev_r;

  logic                   accept;
  logic                   many;
  logic [MAX_SLOTS-1:0]   hit, drop, cand2, after, pass;
  logic [WEIGHT_BITS-1:0] w_d;
  logic [PW-1:0]          r_d;
  logic [CW-1:0]          lhs [MAX_SLOTS];
  logic [CW-1:0]          rhs [MAX_SLOTS];
  logic [IDXW-1:0]        win;
  logic                   made;
  logic                   seen;

  assign q_ready = !out_valid_r || out_ready;
  assign accept  = q_valid && q_ready;

  // under avoid_repeat, drop the prior winner if over one candidate is left
  always_comb begin
    many = (q_cand & (q_cand - 1'b1)) != '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      hit[i] = q_cand[i] && (PB'(i) == prev_r);
    end
    drop  = (avoid_repeat && many) ? hit : '0;
    cand2 = q_cand & ~drop;
    w_d   = '0;
    r_d   = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (drop[i]) begin
        w_d = w_d | q_weight[i];
        r_d = r_d | q_rw[i];
      end
    end
    seen = 1'b0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      after[i] = seen;
      seen     = seen | drop[i];
    end
  end

  // sum > threshold rewritten as (sum << 16) > roll * total, dropped weight
  // taken out of both sides
  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      lhs[i]  = CW'({q_prefix[i], {RB{1'b0}}}) + CW'(r_d);
      rhs[i]  = CW'(q_rt) + (after[i] ? CW'({w_d, {RB{1'b0}}}) : '0);
      pass[i] = cand2[i] && (lhs[i] > rhs[i]);
    end
  end

  // first passing candidate, last candidate as fallback
  always_comb begin
    win = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (cand2[i]) win = IDXW'(i);
    end
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (pass[i]) win = IDXW'(i);
    end
    made = |q_cand;
  end

  // control state and previous winner
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      prev_r      <= wrr_pkg::NO_WINNER;
    end else begin
      if (accept) begin
        out_valid_r <= 1'b1;
        if (made) prev_r <= PB'(win);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      slot_r <= made ? win : '0;
      made_r <= made;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_chosen_slot = slot_r;
  assign out_choice_made = made_r;

endmodule

// ===== rtl/weighted_random_child_pick_core.sv =====
// ----------------------------------------------------------------------------
// weighted_random_child_pick_core
// Roulette wheel pick of one child slot from weighted, eligible slots.
// ----------------------------------------------------------------------------
// Channels: in_if takes one request item (eligibility mask, one weight per
// slot, 16-bit roll); out_if gives one result item per request (chosen slot
// and a choice-made flag); cfg_if writes avoid_repeat (index 0) and
// child_count (index 1), always ready, to be written between requests.
// Path: a request passes three front stages (classify, prefix sums and
// per-slot roll products, roll times total), the queue, then the back
// decision into the output register.
// Throughput: one item per cycle while the receiver takes results. The
// back decides combinationally from the stored previous winner, so that
// loop is the only feedback.
// Reset: clears all stages, the queue and the output register, sets
// avoid_repeat to 0, child_count to 8 and forgets the previous winner.
// Receiver stall: the result is held in the output register; the queue and
// the front stages keep filling, and in_ready falls only once all are full.
// ----------------------------------------------------------------------------
module weighted_random_child_pick_core #(
  parameter int MAX_SLOTS   = wrr_pkg::MAX_SLOTS_DEF,
  parameter int WEIGHT_BITS = wrr_pkg::WEIGHT_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  wrr_in_if.sink   in_if,
  wrr_out_if.source out_if,
  wrr_cfg_if.sink  cfg_if
);

  localparam int RB = wrr_pkg::ROLL_BITS;
  localparam int SW = WEIGHT_BITS + $clog2(MAX_SLOTS);
  localparam int PW = WEIGHT_BITS + RB;
  localparam int TW = SW + RB;
  localparam int QW = MAX_SLOTS * (1 + WEIGHT_BITS + SW + PW) + TW;

  // configuration registers
  logic                             avoid_r;
  logic [wrr_pkg::COUNT_BITS-1:0]   count_r;

  logic                                  f_valid, f_ready;
  logic [MAX_SLOTS-1:0]                  f_cand;
  logic [MAX_SLOTS-1:0][WEIGHT_BITS-1:0] f_weight;
  logic [MAX_SLOTS-1:0][SW-1:0]          f_prefix;
  logic [MAX_SLOTS-1:0][PW-1:0]          f_rw;
  logic [TW-1:0]                         f_rt;

  logic                                  b_valid, b_ready;
  logic [QW-1:0]                         q_wdata, q_rdata;
  logic [MAX_SLOTS-1:0]                  b_cand;
  logic [MAX_SLOTS-1:0][WEIGHT_BITS-1:0] b_weight;
  logic [MAX_SLOTS-1:0][SW-1:0]          b_prefix;
  logic [MAX_SLOTS-1:0][PW-1:0]          b_rw;
  logic [TW-1:0]                         b_rt;

  // register writes
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avoid_r <= 1'b0;
      count_r <= wrr_pkg::CHILD_COUNT_RESET;
    end else if (cfg_if.valid) begin
      unique case (wrr_pkg::cfg_reg_t'(cfg_if.index))
        wrr_pkg::CFG_AVOID_REPEAT: avoid_r <= cfg_if.data[0];
        wrr_pkg::CFG_CHILD_COUNT:  count_r <= cfg_if.data[wrr_pkg::COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // front: classify and precompute
  wrr_front #(
    .MAX_SLOTS   (MAX_SLOTS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_if.valid),
    .in_ready    (in_if.ready),
    .in_mask     (in_if.eligible_mask),
    .in_weight   (in_if.weight),
    .in_roll     (in_if.roll),
    .child_count (count_r),
    .out_valid   (f_valid),
    .out_ready   (f_ready),
    .out_cand    (f_cand),
    .out_weight  (f_weight),
    .out_prefix  (f_prefix),
    .out_rw      (f_rw),
    .out_rt      (f_rt)
  );

  // queue between front and back
  assign q_wdata = {f_cand, f_weight, f_prefix, f_rw, f_rt};
  assign {b_cand, b_weight, b_prefix, b_rw, b_rt} = q_rdata;

  wrr_queue #(
    .WIDTH (QW),
    .DEPTH (wrr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (q_wdata),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (q_rdata)
  );

  // back: decide and hold the result
  wrr_back #(
    .MAX_SLOTS   (MAX_SLOTS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .avoid_repeat    (avoid_r),
    .q_valid         (b_valid),
    .q_ready         (b_ready),
    .q_cand          (b_cand),
    .q_weight        (b_weight),
    .q_prefix        (b_prefix),
    .q_rw            (b_rw),
    .q_rt            (b_rt),
    .out_valid       (out_if.valid),
    .out_ready       (out_if.ready),
    .out_chosen_slot (out_if.chosen_slot),
    .out_choice_made (out_if.choice_made)
  );

endmodule

// ===== rtl/wrr_checker.sv =====
// ----------------------------------------------------------------------------
// wrr_checker
// Port level checks on the weighted random child pick, bound to the top.
// ----------------------------------------------------------------------------
module wrr_checker #(
  parameter int MAX_SLOTS = wrr_pkg::MAX_SLOTS_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [$clog2(MAX_SLOTS)-1:0] chosen_slot,
  input logic                         choice_made
);

  // reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(chosen_slot) && $stable(choice_made))
    else $error("stalled result changed");

  // no choice always reports slot zero
  a_no_choice_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !choice_made |-> chosen_slot == '0)
    else $error("slot nonzero without a choice");

  // requests are only refused after the receiver has stalled
  a_backpressure_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("request refused without a stalled result");

endmodule

bind weighted_random_child_pick_core wrr_checker #(
  .MAX_SLOTS (MAX_SLOTS)
) u_wrr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .chosen_slot (out_if.chosen_slot),
  .choice_made (out_if.choice_made)
);
